// ----- src/positional_array_list_core_defines.svh -----
// Assertion macros shared by the positional array list RTL.
// Used by pal_ctrl and pal_datapath; expects i_clk and i_rst_n in scope.
`ifndef POSITIONAL_ARRAY_LIST_CORE_DEFINES_SVH
`define POSITIONAL_ARRAY_LIST_CORE_DEFINES_SVH

// Same-cycle implication, masked while reset is applied.
`define PAL_CHK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is applied.
`define PAL_CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/pal_pkg.sv -----
// Package for the positional array list: sizes, opcode and status codes,
// FSM state type, controller/datapath command and status structs, word compare. No dependencies.
`timescale 1ns / 1ps

package pal_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = 7;
    localparam int POS_W    = 7;
    localparam int OP_W     = 3;
    localparam int WORD_W   = 32;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
    localparam logic [OP_W-1:0] OP_MODIFY = 3'd2;
    localparam logic [OP_W-1:0] OP_READ   = 3'd3;
    localparam logic [OP_W-1:0] OP_FIND   = 3'd4;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SHIFT,
        S_FIND,
        S_RDWAIT
    } t_state;

    typedef struct packed {
        logic    latch;      // capture request fields
        logic    step;       // one read of the shift/search sweep
        logic    rd_pos;     // read entry at position
        logic    wr_val;     // write request value at position
        logic    finish;     // load result registers, pulse strobe
        logic    cnt_inc;
        logic    cnt_dec;
        logic    fin_rd;     // result carries read data
        logic    fin_found;  // result carries matched position
        t_status fin_status;
    } t_ctl_cmd;

    typedef struct packed {
        logic [OP_W-1:0] opcode;
        logic            full;
        logic            range_ok;
        logic            more;   // sweep has entries left
        logic            wpend;  // shift write still in flight
        logic            match;  // compare hit on last read word
    } t_dp_sts;

    // IEEE single-precision equality on raw bit patterns.
    function automatic logic words_equal(input logic [WORD_W-1:0] a,
                                         input logic [WORD_W-1:0] b);
        logic a_nan;
        logic b_nan;
        a_nan = (a[30:0] > 31'h7F80_0000);
        b_nan = (b[30:0] > 31'h7F80_0000);
        return !a_nan && !b_nan && ((((a | b) & 32'h7FFF_FFFF) == 32'd0) || (a == b));
    endfunction

endpackage

// ----- src/pal_ctrl.sv -----
// Controller FSM for the positional array list.
// Depends on pal_pkg; drives t_ctl_cmd to pal_datapath and reads t_dp_sts back.
`timescale 1ns / 1ps

module pal_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  pal_pkg::t_dp_sts  i_sts,
    output pal_pkg::t_ctl_cmd o_cmd
);

    `include "positional_array_list_core_defines.svh"

    pal_pkg::t_state r_state;
    pal_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pal_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != pal_pkg::S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.fin_status = pal_pkg::ST_OK;
        unique case (r_state)
            pal_pkg::S_IDLE: begin
                if (start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = pal_pkg::S_CHECK;
                end
            end
            pal_pkg::S_CHECK: begin
                unique case (i_sts.opcode) inside
                    pal_pkg::OP_INSERT: begin
                        if (i_sts.full) begin
                            o_cmd.finish     = 1'b1;
                            o_cmd.fin_status = pal_pkg::ST_FULL;
                            n_state          = pal_pkg::S_IDLE;
                        end else if (!i_sts.range_ok) begin
                            o_cmd.finish     = 1'b1;
                            o_cmd.fin_status = pal_pkg::ST_RANGE;
                            n_state          = pal_pkg::S_IDLE;
                        end else begin
                            n_state = pal_pkg::S_SHIFT;
                        end
                    end
                    pal_pkg::OP_DELETE, pal_pkg::OP_MODIFY, pal_pkg::OP_READ: begin
                        if (!i_sts.range_ok) begin
                            o_cmd.finish     = 1'b1;
                            o_cmd.fin_status = pal_pkg::ST_RANGE;
                            n_state          = pal_pkg::S_IDLE;
                        end else if (i_sts.opcode == pal_pkg::OP_DELETE) begin
                            n_state = pal_pkg::S_SHIFT;
                        end else if (i_sts.opcode == pal_pkg::OP_MODIFY) begin
                            o_cmd.wr_val = 1'b1;
                            o_cmd.finish = 1'b1;
                            n_state      = pal_pkg::S_IDLE;
                        end else begin
                            o_cmd.rd_pos = 1'b1;
                            n_state      = pal_pkg::S_RDWAIT;
                        end
                    end
                    pal_pkg::OP_FIND: begin
                        n_state = pal_pkg::S_FIND;
                    end
                    default: begin
                        // undefined opcode: no change, plain OK result
                        o_cmd.finish = 1'b1;
                        n_state      = pal_pkg::S_IDLE;
                    end
                endcase
            end
            pal_pkg::S_SHIFT: begin
                if (i_sts.more) begin
                    o_cmd.step = 1'b1;
                end else if (!i_sts.wpend) begin
                    // sweep drained; insert still owes the new word
                    o_cmd.finish = 1'b1;
                    if (i_sts.opcode == pal_pkg::OP_INSERT) begin
                        o_cmd.wr_val  = 1'b1;
                        o_cmd.cnt_inc = 1'b1;
                    end else begin
                        o_cmd.cnt_dec = 1'b1;
                    end
                    n_state = pal_pkg::S_IDLE;
                end
            end
            pal_pkg::S_FIND: begin
                if (i_sts.match) begin
                    o_cmd.finish    = 1'b1;
                    o_cmd.fin_found = 1'b1;
                    n_state         = pal_pkg::S_IDLE;
                end else if (i_sts.more) begin
                    o_cmd.step = 1'b1;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state      = pal_pkg::S_IDLE;
                end
            end
            pal_pkg::S_RDWAIT: begin
                o_cmd.finish = 1'b1;
                o_cmd.fin_rd = 1'b1;
                n_state      = pal_pkg::S_IDLE;
            end
            default: begin
                n_state = pal_pkg::S_IDLE;
            end
        endcase
    end

    `PAL_CHK_NOW(a_one_write_port, o_cmd.wr_val, !i_sts.wpend, "write port collision")
    `PAL_CHK_NOW(a_step_in_range, o_cmd.step, i_sts.more, "sweep step past end of list")
    `PAL_CHK_NEXT(a_latch_to_check, o_cmd.latch, r_state == pal_pkg::S_CHECK, "latch not followed by check")

endmodule

// ----- src/pal_datapath.sv -----
// Datapath for the positional array list: entry memory, count, sweep index,
// shift/search pipeline and result registers. Depends on pal_pkg.
`timescale 1ns / 1ps

module pal_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [pal_pkg::OP_W-1:0]      i_opcode,
    input  logic [pal_pkg::POS_W-1:0]     i_position,
    input  logic [pal_pkg::WORD_W-1:0]    i_value,
    input  pal_pkg::t_ctl_cmd             i_cmd,
    output pal_pkg::t_dp_sts              o_sts,
    output logic                          o_done,
    output logic [pal_pkg::WORD_W-1:0]    o_read_value,
    output logic [pal_pkg::POS_W-1:0]     o_found_position,
    output logic [pal_pkg::CNT_W-1:0]     o_entry_count,
    output logic                          o_is_empty,
    output logic [1:0]                    o_status
);

    `include "positional_array_list_core_defines.svh"

    logic [pal_pkg::WORD_W-1:0] mem [pal_pkg::CAPACITY];

    logic [pal_pkg::OP_W-1:0]    r_op;
    logic [pal_pkg::POS_W-1:0]   r_pos;
    logic [pal_pkg::WORD_W-1:0]  r_val;
    logic [pal_pkg::CNT_W-1:0]   r_idx;
    logic [pal_pkg::CNT_W-1:0]   r_count;
    logic                        r_wpend;
    logic [pal_pkg::ADDR_W-1:0]  r_waddr;
    logic                        r_cpend;
    logic [pal_pkg::ADDR_W-1:0]  r_caddr;
    logic [pal_pkg::WORD_W-1:0]  r_rdata;
    logic                        r_done;
    logic [pal_pkg::WORD_W-1:0]  r_read_value;
    logic [pal_pkg::POS_W-1:0]   r_found_position;
    logic [pal_pkg::CNT_W-1:0]   r_entry_count;
    logic                        r_is_empty;
    logic [1:0]                  r_status;

    logic                        is_ins;
    logic                        is_del;
    logic                        is_find;
    logic [pal_pkg::POS_W-1:0]   pos0;
    logic [pal_pkg::CNT_W-1:0]   idx_m1;
    logic [pal_pkg::CNT_W:0]     pos_lim;
    logic                        rd_en;
    logic [pal_pkg::ADDR_W-1:0]  rd_addr;
    logic                        wr_en;
    logic [pal_pkg::ADDR_W-1:0]  wr_addr;
    logic [pal_pkg::WORD_W-1:0]  wr_data;
    logic [pal_pkg::CNT_W-1:0]   n_count;
    logic [pal_pkg::CNT_W-1:0]   n_idx;

    assign is_ins  = (r_op == pal_pkg::OP_INSERT);
    assign is_del  = (r_op == pal_pkg::OP_DELETE);
    assign is_find = (r_op == pal_pkg::OP_FIND);
    assign pos0    = r_pos - 7'd1;
    assign idx_m1  = r_idx - 7'd1;
    assign pos_lim = is_ins ? ({1'b0, r_count} + 8'd1) : {1'b0, r_count};

    always_comb begin
        o_sts.opcode   = r_op;
        o_sts.full     = (r_count == pal_pkg::CAP_CNT);
        o_sts.range_ok = (r_pos != 7'd0) && ({1'b0, r_pos} <= pos_lim);
        // insert walks down to the slot; delete and find walk up to the count
        o_sts.more     = is_ins ? (r_idx > pos0) : (r_idx < r_count);
        o_sts.wpend    = r_wpend;
        o_sts.match    = r_cpend && pal_pkg::words_equal(r_rdata, r_val);
    end

    // read port: one address per cycle, data registered
    assign rd_en   = i_cmd.rd_pos || i_cmd.step;
    assign rd_addr = i_cmd.rd_pos ? pos0[pal_pkg::ADDR_W-1:0] :
                     is_ins       ? idx_m1[pal_pkg::ADDR_W-1:0] :
                                    r_idx[pal_pkg::ADDR_W-1:0];

    // write port: shift data in the cycle after its read, else the request value
    assign wr_en   = r_wpend || i_cmd.wr_val;
    assign wr_addr = r_wpend ? r_waddr : pos0[pal_pkg::ADDR_W-1:0];
    assign wr_data = r_wpend ? r_rdata : r_val;

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_comb begin
        n_idx = r_idx;
        if (i_cmd.latch) begin
            if (i_opcode == pal_pkg::OP_INSERT) begin
                n_idx = r_count;
            end else if (i_opcode == pal_pkg::OP_DELETE) begin
                n_idx = i_position;
            end else begin
                n_idx = '0;
            end
        end else if (i_cmd.step) begin
            n_idx = is_ins ? idx_m1 : (r_idx + 7'd1);
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.cnt_inc) begin
            n_count = r_count + 7'd1;
        end else if (i_cmd.cnt_dec) begin
            n_count = r_count - 7'd1;
        end
    end

    // request and sweep payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op  <= i_opcode;
            r_pos <= i_position;
            r_val <= i_value;
        end
        r_idx <= n_idx;
        if (i_cmd.step) begin
            r_waddr <= is_ins ? r_idx[pal_pkg::ADDR_W-1:0] : idx_m1[pal_pkg::ADDR_W-1:0];
            r_caddr <= r_idx[pal_pkg::ADDR_W-1:0];
        end
        if (i_cmd.finish) begin
            r_read_value     <= i_cmd.fin_rd ? r_rdata : '0;
            r_found_position <= i_cmd.fin_found ? ({1'b0, r_caddr} + 7'd1) : '0;
            r_entry_count    <= n_count;
            r_is_empty       <= (n_count == 7'd0);
            r_status         <= i_cmd.fin_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_wpend <= 1'b0;
            r_cpend <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_wpend <= i_cmd.step && (is_ins || is_del);
            r_cpend <= i_cmd.step && is_find;
            r_done  <= i_cmd.finish;
        end
    end

    assign o_done           = r_done;
    assign o_read_value     = r_read_value;
    assign o_found_position = r_found_position;
    assign o_entry_count    = r_entry_count;
    assign o_is_empty       = r_is_empty;
    assign o_status         = r_status;

    `PAL_CHK_NOW(a_inc_not_full, i_cmd.cnt_inc, r_count < pal_pkg::CAP_CNT, "insert on full list")
    `PAL_CHK_NOW(a_dec_not_empty, i_cmd.cnt_dec, r_count != 7'd0, "delete on empty list")
    `PAL_CHK_NEXT(a_done_spaced, r_done, !r_done, "result strobes back to back")

endmodule

// ----- src/positional_array_list_core.sv -----
// Top level of the positional array list: controller plus datapath.
// Depends on pal_pkg, pal_ctrl and pal_datapath.
//
//   channel   handshake             fields
//   request   start & !busy         i_opcode, i_position, i_value
//   result    o_done (one cycle)    o_read_value, o_found_position, o_entry_count,
//                                   o_is_empty, o_status
//
// Every accepted request passes S_CHECK; modify, reserved and refused requests finish there,
// read adds S_RDWAIT. Insert and delete sweep the entry memory (one read, one write port)
//   one entry a cycle in S_SHIFT; find sweeps in S_FIND until a hit or the end of the list.
// busy stays high until the cycle the strobe is set; the next request may come with it.
// Reset (i_rst_n low, synchronous) empties the list; entry contents are not cleared.
// Results cannot be held off; each is shown for one cycle only.
`timescale 1ns / 1ps

module positional_array_list_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [pal_pkg::OP_W-1:0]      i_opcode,
    input  logic [pal_pkg::POS_W-1:0]     i_position,
    input  logic [pal_pkg::WORD_W-1:0]    i_value,
    output logic                          o_done,
    output logic [pal_pkg::WORD_W-1:0]    o_read_value,
    output logic [pal_pkg::POS_W-1:0]     o_found_position,
    output logic [pal_pkg::CNT_W-1:0]     o_entry_count,
    output logic                          o_is_empty,
    output logic [1:0]                    o_status
);

    pal_pkg::t_ctl_cmd cmd;
    pal_pkg::t_dp_sts  sts;

    pal_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    pal_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_opcode         (i_opcode),
        .i_position       (i_position),
        .i_value          (i_value),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_done           (o_done),
        .o_read_value     (o_read_value),
        .o_found_position (o_found_position),
        .o_entry_count    (o_entry_count),
        .o_is_empty       (o_is_empty),
        .o_status         (o_status)
    );

endmodule

// ----- verif/positional_array_list_checker.sv -----
// Checker for positional_array_list_core: keeps its own copy of the list, predicts every
// result at request acceptance and compares each strobed result in order.
// Depends on pal_pkg.
`timescale 1ns / 1ps

module positional_array_list_checker
    import pal_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic [OP_W-1:0]    i_opcode,
    input  logic [POS_W-1:0]   i_position,
    input  logic [WORD_W-1:0]  i_value,
    input  logic               i_done,
    input  logic [WORD_W-1:0]  i_read_value,
    input  logic [POS_W-1:0]   i_found_position,
    input  logic [CNT_W-1:0]   i_entry_count,
    input  logic               i_is_empty,
    input  logic [1:0]         i_status,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_list_len
);

    typedef struct packed {
        logic [WORD_W-1:0] rd;
        logic [POS_W-1:0]  found;
        logic [CNT_W-1:0]  cnt;
        logic              empty;
        t_status           st;
    } t_list_reply;

    logic [WORD_W-1:0] list_mem [CAPACITY];
    int                list_len;
    t_list_reply       expected_replies [$];
    t_list_reply       want;
    t_list_reply       got;
    int                n_mismatch;

    assign o_errors = n_mismatch;

    // IEEE compare on raw patterns: NaN never equal, signed zeros equal.
    function automatic bit same_float(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b);
        bit a_nan;
        bit b_nan;
        a_nan = (a[30:23] == 8'hFF) && (a[22:0] != '0);
        b_nan = (b[30:23] == 8'hFF) && (b[22:0] != '0);
        if (a_nan || b_nan)
            return 1'b0;
        if (a[30:0] == '0 && b[30:0] == '0)
            return 1'b1;
        return a == b;
    endfunction

    function automatic t_list_reply list_apply(input logic [OP_W-1:0]   op,
                                               input logic [POS_W-1:0]  pos,
                                               input logic [WORD_W-1:0] val);
        t_list_reply r;
        int p;
        int k;
        r = '0;
        r.st = ST_OK;
        p = int'(pos);
        case (op) inside
            OP_INSERT: begin
                if (list_len >= CAPACITY) begin
                    r.st = ST_FULL;
                end else if (p < 1 || p > list_len + 1) begin
                    r.st = ST_RANGE;
                end else begin
                    for (k = list_len; k >= p; k--)
                        list_mem[k] = list_mem[k-1];
                    list_mem[p-1] = val;
                    list_len++;
                end
            end
            OP_DELETE, OP_MODIFY, OP_READ: begin
                if (p < 1 || p > list_len) begin
                    r.st = ST_RANGE;
                end else if (op == OP_DELETE) begin
                    for (k = p; k < list_len; k++)
                        list_mem[k-1] = list_mem[k];
                    list_len--;
                end else if (op == OP_MODIFY) begin
                    list_mem[p-1] = val;
                end else begin
                    r.rd = list_mem[p-1];
                end
            end
            OP_FIND: begin
                for (k = 0; k < list_len && r.found == '0; k++)
                    if (same_float(list_mem[k], val))
                        r.found = POS_W'(k + 1);
            end
            default: ;  // reserved opcodes leave the list alone
        endcase
        r.cnt   = CNT_W'(list_len);
        r.empty = (list_len == 0);
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            list_len = 0;
            expected_replies.delete();
        end else begin
            // result first: a request accepted on the strobe cycle belongs behind it
            if (i_done) begin
                got = '{i_read_value, i_found_position, i_entry_count, i_is_empty,
                        t_status'(i_status)};
                if (expected_replies.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("%0t: result with no transaction pending", $time);
                end else begin
                    want = expected_replies.pop_front();
                    if (got !== want) begin
                        n_mismatch++;
                        if (n_mismatch <= 10) begin
                            $display("%0t: mismatch exp rd %h found %0d count %0d empty %0d st %0d",
                                     $time, want.rd, want.found, want.cnt, want.empty, want.st);
                            $display("%0t:          got rd %h found %0d count %0d empty %0d st %0d",
                                     $time, got.rd, got.found, got.cnt, got.empty, got.st);
                        end
                    end
                end
            end
            if (i_start && !i_busy)
                expected_replies.push_back(list_apply(i_opcode, i_position, i_value));
        end
        o_pending  <= expected_replies.size();
        o_list_len <= list_len;
    end

endmodule

// ----- verif/positional_array_list_core_test.sv -----
// Testbench top for positional_array_list_core: clock, reset, request stimulus with
// random gaps, and the verdict. Depends on pal_pkg and positional_array_list_checker.
`timescale 1ns / 1ps

module positional_array_list_core_test;
    import pal_pkg::*;

    localparam logic [OP_W-1:0] OP_RSVD_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_MID   = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_LAST  = 3'd7;
    localparam int RANDOM_ITEMS = 1450;

    typedef enum int {PH_FILL, PH_MIXED, PH_DRAIN} t_mix;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [OP_W-1:0]    req_opcode;
    logic [POS_W-1:0]   req_position;
    logic [WORD_W-1:0]  req_value;
    logic               rsp_done;
    logic [WORD_W-1:0]  rsp_read_value;
    logic [POS_W-1:0]   rsp_found_position;
    logic [CNT_W-1:0]   rsp_entry_count;
    logic               rsp_is_empty;
    logic [1:0]         rsp_status;
    int                 n_errors;
    int                 n_pending;
    int                 list_len;
    bit                 no_gaps;

    positional_array_list_core u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_opcode         (req_opcode),
        .i_position       (req_position),
        .i_value          (req_value),
        .o_done           (rsp_done),
        .o_read_value     (rsp_read_value),
        .o_found_position (rsp_found_position),
        .o_entry_count    (rsp_entry_count),
        .o_is_empty       (rsp_is_empty),
        .o_status         (rsp_status)
    );

    positional_array_list_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_opcode         (req_opcode),
        .i_position       (req_position),
        .i_value          (req_value),
        .i_done           (rsp_done),
        .i_read_value     (rsp_read_value),
        .i_found_position (rsp_found_position),
        .i_entry_count    (rsp_entry_count),
        .i_is_empty       (rsp_is_empty),
        .i_status         (rsp_status),
        .o_errors         (n_errors),
        .o_pending        (n_pending),
        .o_list_len       (list_len)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    initial begin
        #1500000;
        $display("== FAIL ==");
        $finish;
    end

    // start is left high after acceptance so back-to-back requests need no gap
    task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                input logic [WORD_W-1:0] val);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        req_opcode   <= op;
        req_position <= pos;
        req_value    <= val;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic wait_quiet();
        start <= 1'b0;
        @(posedge i_clk);
        while (n_pending != 0)
            @(posedge i_clk);
    endtask

    // Half the words come from a pool of signed zeros, +-1.0, infinities, NaNs and a denormal so finds hit.
    function automatic logic [WORD_W-1:0] pick_value();
        if ($urandom_range(0, 1))
            return $urandom;
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'h8000_0000;
            2:       return 32'h3F80_0000;
            3:       return 32'hBF80_0000;
            4:       return 32'h7F80_0000;
            5:       return 32'hFF80_0000;
            6:       return 32'h7FC0_0000;
            7:       return 32'h7F80_0001;
            8:       return 32'h0000_0001;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_position(input logic [OP_W-1:0] op);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return POS_W'($urandom_range(0, 127));
        if (op == OP_INSERT) begin
            if (sel == 1) return 1;
            if (sel == 2) return POS_W'(list_len + 1);
            return POS_W'($urandom_range(1, list_len + 1));
        end
        if (list_len == 0)
            return POS_W'($urandom_range(0, 2));
        if (sel == 1) return 1;
        if (sel == 2) return POS_W'(list_len);
        return POS_W'($urandom_range(1, list_len));
    endfunction

    function automatic logic [OP_W-1:0] pick_opcode(input t_mix mix);
        int r;
        int ins_w;
        int del_w;
        r = $urandom_range(0, 99);
        case (mix)
            PH_FILL:  begin ins_w = 85; del_w = 3;  end
            PH_DRAIN: begin ins_w = 8;  del_w = 80; end
            default:  begin ins_w = 30; del_w = 25; end
        endcase
        if (r < 2)
            return OP_W'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
        if (r < 2 + ins_w)
            return OP_INSERT;
        if (r < 2 + ins_w + del_w)
            return OP_DELETE;
        case ($urandom_range(0, 2))
            0:       return OP_MODIFY;
            1:       return OP_READ;
            default: return OP_FIND;
        endcase
    endfunction

    initial begin
        int    n_items;
        int    phase_idx;
        int    phase_len;
        int    k;
        t_mix  mix;
        logic [OP_W-1:0] op;

        i_rst_n      = 1'b0;
        start        = 1'b0;
        req_opcode   = OP_INSERT;
        req_position = '0;
        req_value    = '0;
        no_gaps      = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty list: every positional op is refused, find misses
        send_request(OP_READ,   1, 32'h1234_5678);
        send_request(OP_DELETE, 1, 32'h0);
        send_request(OP_MODIFY, 1, 32'hDEAD_BEEF);
        send_request(OP_FIND,   0, 32'h0);
        send_request(OP_INSERT, 0, 32'h3F80_0000);
        send_request(OP_INSERT, 2, 32'h3F80_0000);
        // front, end and middle inserts around signed zeros and NaNs
        send_request(OP_INSERT, 1, 32'h0000_0000);
        send_request(OP_INSERT, 2, 32'h7FC0_0000);
        send_request(OP_INSERT, 1, 32'h7F80_0000);
        send_request(OP_FIND,   0, 32'h8000_0000);
        send_request(OP_FIND,   0, 32'h7FC0_0000);
        send_request(OP_FIND,   0, 32'h7F80_0000);
        send_request(OP_INSERT, 4, 32'h7F80_0001);
        send_request(OP_FIND,   0, 32'h7F80_0001);
        send_request(OP_INSERT, 2, 32'h8000_0000);
        send_request(OP_FIND,   0, 32'hFF80_0000);
        send_request(OP_MODIFY, 3, 32'hFFFF_FFFF);
        send_request(OP_READ,   3, 32'h0);
        send_request(OP_READ,   6, 32'h0);
        send_request(OP_READ,   127, 32'hFFFF_FFFF);
        send_request(OP_DELETE, 2, 32'h0);
        send_request(OP_DELETE, 4, 32'h0);
        send_request(OP_RSVD_FIRST, 1, 32'hA5A5_A5A5);
        send_request(OP_RSVD_MID, 127, 32'h5A5A_5A5A);
        send_request(OP_RSVD_LAST, 2, 32'hFFFF_FFFF);
        wait_quiet();

        // fill, mix, drain, mix in turn; half the time hold off until idle between phases
        n_items   = 0;
        phase_idx = 0;
        while (n_items < RANDOM_ITEMS) begin
            case (phase_idx % 4)
                0:       begin mix = PH_FILL;  phase_len = 120; end
                2:       begin mix = PH_DRAIN; phase_len = 100; end
                default: begin mix = PH_MIXED; phase_len = 60;  end
            endcase
            no_gaps = ($urandom_range(0, 2) == 0);
            for (k = 0; k < phase_len && n_items < RANDOM_ITEMS; k++) begin
                op = pick_opcode(mix);
                send_request(op, pick_position(op), pick_value());
                if (op < OP_RSVD_FIRST)
                    n_items++;
            end
            if ($urandom_range(0, 1))
                wait_quiet();
            phase_idx++;
        end
        no_gaps = 1'b0;

        wait_quiet();
        repeat (100) @(posedge i_clk);
        if (n_errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
